// ===== sv/dssm_pkg.sv =====
package dssm_pkg;

  localparam int KEY_W    = 32;
  localparam int POS_W    = 6;
  localparam int CNT_W    = 7;
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 64;
  localparam int OUT_TUSER_W = 2;
  localparam int OUT_PAD_W   = OUT_TDATA_W - KEY_W - POS_W - 3 * CNT_W;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_PEEK  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // result of one beat, minus the word that comes back from memory
  typedef struct packed {
    status_t          status;
    logic             rd_key;
    logic [POS_W-1:0] position;
    logic [CNT_W-1:0] count_first;
    logic [CNT_W-1:0] count_second;
    logic [CNT_W-1:0] count_total;
  } info_t;

endpackage

// ===== sv/dssm_ram.sv =====
module dssm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/dssm_ctrl.sv =====
module dssm_ctrl #(
  parameter int DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  dssm_pkg::action_t                   action,
  input  logic                                stack_select,
  input  logic [dssm_pkg::KEY_W-1:0]          key_in,
  output logic                                ram_we,
  output logic [$clog2(DEPTH)-1:0]            ram_waddr,
  output logic [dssm_pkg::KEY_W-1:0]          ram_wdata,
  output logic                                ram_re,
  output logic [$clog2(DEPTH)-1:0]            ram_raddr,
  output dssm_pkg::info_t                     info
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] up_r, up_nxt;
  logic [CW-1:0] dn_r, dn_nxt;
  logic [CW:0]   sum;
  logic [CW-1:0] cnt;
  logic          full;
  logic          empty;
  logic          we;
  logic          re;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  dssm_pkg::status_t status;

  assign sum   = {1'b0, up_r} + {1'b0, dn_r};
  assign full  = sum >= (CW + 1)'(DEPTH);
  assign cnt   = stack_select ? dn_r : up_r;
  assign empty = cnt == '0;

  always_comb begin
    up_nxt = up_r;
    dn_nxt = dn_r;
    we     = 1'b0;
    re     = 1'b0;
    waddr  = AW'(up_r);
    raddr  = '0;
    status = dssm_pkg::ST_OK;
    case (action)
      dssm_pkg::ACT_PUSH: begin
        if (full) begin
          status = dssm_pkg::ST_FULL;
        end else if (!stack_select) begin
          we     = 1'b1;
          waddr  = AW'(up_r);
          up_nxt = up_r + 1'b1;
        end else begin
          we     = 1'b1;
          waddr  = AW'(CW'(DEPTH - 1) - dn_r);
          dn_nxt = dn_r + 1'b1;
        end
      end
      dssm_pkg::ACT_POP, dssm_pkg::ACT_PEEK: begin
        if (empty) begin
          status = dssm_pkg::ST_EMPTY;
        end else begin
          re    = 1'b1;
          raddr = stack_select ? AW'(CW'(DEPTH) - cnt) : AW'(cnt - 1'b1);
          if (action == dssm_pkg::ACT_POP) begin
            if (stack_select) begin
              dn_nxt = dn_r - 1'b1;
            end else begin
              up_nxt = up_r - 1'b1;
            end
          end
        end
      end
      dssm_pkg::ACT_CLEAR: begin
        up_nxt = '0;
        dn_nxt = '0;
      end
      default: begin
        up_nxt = up_r;
        dn_nxt = dn_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_r <= '0;
      dn_r <= '0;
    end else if (accept) begin
      up_r <= up_nxt;
      dn_r <= dn_nxt;
    end
  end

  assign ram_we    = accept && we;
  assign ram_waddr = waddr;
  assign ram_wdata = key_in;
  assign ram_re    = accept && re;
  assign ram_raddr = raddr;

  always_comb begin
    info.status       = status;
    info.rd_key       = re;
    info.position     = re ? dssm_pkg::POS_W'(raddr) : '0;
    info.count_first  = dssm_pkg::CNT_W'(up_nxt);
    info.count_second = dssm_pkg::CNT_W'(dn_nxt);
    info.count_total  = dssm_pkg::CNT_W'({1'b0, up_nxt} + {1'b0, dn_nxt});
  end

endmodule

// ===== sv/dual_stack_shared_memory.sv =====
// Two LIFO stacks in one DEPTH-word memory: stack 0 grows up from address 0, stack 1
// grows down from DEPTH-1. A push fails (status full) once both together hold DEPTH
// words; pop or peek on an empty stack returns status empty. Clear resets both counts
// and leaves memory alone. One beat is taken every cycle unless out_tready holds a
// full output register back; its result passes through the synchronous memory read
// and then the output register. Counts are updated and writes land at the accept edge,
// so a read on the next beat already sees the word just pushed.
module dual_stack_shared_memory #(
  parameter int DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [dssm_pkg::IN_TDATA_W-1:0]     in_tdata,  // key_in
  input  logic [dssm_pkg::IN_TUSER_W-1:0]     in_tuser,  // action[1:0], stack_select
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // key_out, position, count_first, count_second, count_total, zero pad
  output logic [dssm_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [dssm_pkg::OUT_TUSER_W-1:0]    out_tuser  // status
);

  localparam int AW = $clog2(DEPTH);

  logic                            accept;
  logic                            advance;
  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [dssm_pkg::KEY_W-1:0]      ram_wdata;
  logic                            ram_re;
  logic [AW-1:0]                   ram_raddr;
  logic [dssm_pkg::KEY_W-1:0]      ram_rdata;
  logic [dssm_pkg::KEY_W-1:0]      key_out;
  dssm_pkg::info_t                 info;
  dssm_pkg::info_t                 p_info_r;
  logic                            p_valid_r;
  logic                            out_valid_r;
  logic [dssm_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic [dssm_pkg::OUT_TUSER_W-1:0] out_tuser_r;

  // the read stage only moves on together with the output register
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !p_valid_r || advance;
  assign accept    = in_tvalid && in_tready;

  dssm_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .action       (dssm_pkg::action_t'(in_tuser[1:0])),
    .stack_select (in_tuser[2]),
    .key_in       (in_tdata[dssm_pkg::KEY_W-1:0]),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .info         (info)
  );

  // read data holds while the read stage stalls: no new read is issued then
  dssm_ram #(
    .WIDTH(dssm_pkg::KEY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign key_out = p_info_r.rd_key ? ram_rdata : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        p_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= p_valid_r;
      end
    end
    if (accept) begin
      p_info_r <= info;
    end
    if (advance && p_valid_r) begin
      out_tdata_r <= {{dssm_pkg::OUT_PAD_W{1'b0}}, p_info_r.count_total,
                      p_info_r.count_second, p_info_r.count_first,
                      p_info_r.position, key_out};
      out_tuser_r <= p_info_r.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ===== test/stack_result_checker.sv =====
`timescale 1ns / 100ps

module stack_result_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [dssm_pkg::IN_TDATA_W-1:0]  in_tdata,   // key_in
  input  logic [dssm_pkg::IN_TUSER_W-1:0]  in_tuser,   // action[1:0], stack_select
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  // key_out, position, count_first, count_second, count_total, zero pad
  input  logic [dssm_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic [dssm_pkg::OUT_TUSER_W-1:0] out_tuser,  // status
  output int                               mismatches,
  output int                               pending_beats,
  output int                               results_seen,
  output int                               full_seen,
  output int                               empty_seen
);

  localparam int DEPTH  = 64;
  localparam int POS_LO = dssm_pkg::KEY_W;
  localparam int C1_LO  = POS_LO + dssm_pkg::POS_W;
  localparam int C2_LO  = C1_LO + dssm_pkg::CNT_W;
  localparam int CT_LO  = C2_LO + dssm_pkg::CNT_W;

  typedef struct {
    dssm_pkg::status_t          status;
    logic [dssm_pkg::KEY_W-1:0] key;
    logic [dssm_pkg::POS_W-1:0] pos;
    logic [dssm_pkg::CNT_W-1:0] cnt_up;
    logic [dssm_pkg::CNT_W-1:0] cnt_down;
    logic [dssm_pkg::CNT_W-1:0] cnt_total;
  } stack_result_t;

  logic [dssm_pkg::KEY_W-1:0] word_mem [DEPTH];
  int unsigned                up_depth;
  int unsigned                down_depth;
  stack_result_t              expected_q [$];
  int                         err_cnt;
  int                         got_cnt;
  int                         full_cnt;
  int                         empty_cnt;

  // one beat applied to the predicted stack pair
  function automatic stack_result_t apply_stack_action(dssm_pkg::action_t act, logic sel,
                                                       logic [dssm_pkg::KEY_W-1:0] key);
    stack_result_t r;
    int unsigned   cnt;
    int unsigned   idx;
    r.status = dssm_pkg::ST_OK;
    r.key    = '0;
    r.pos    = '0;
    case (act)
      dssm_pkg::ACT_PUSH: begin
        if (up_depth + down_depth >= DEPTH) begin
          r.status = dssm_pkg::ST_FULL;
        end else if (!sel) begin
          word_mem[up_depth] = key;
          up_depth++;
        end else begin
          word_mem[DEPTH - 1 - down_depth] = key;
          down_depth++;
        end
      end
      dssm_pkg::ACT_POP, dssm_pkg::ACT_PEEK: begin
        cnt = sel ? down_depth : up_depth;
        if (cnt == 0) begin
          r.status = dssm_pkg::ST_EMPTY;
        end else begin
          idx   = sel ? DEPTH - cnt : cnt - 1;
          r.pos = dssm_pkg::POS_W'(idx);
          r.key = word_mem[idx];
          if (act == dssm_pkg::ACT_POP) begin
            if (sel) down_depth--;
            else up_depth--;
          end
        end
      end
      default: begin
        up_depth   = 0;
        down_depth = 0;
      end
    endcase
    r.cnt_up    = dssm_pkg::CNT_W'(up_depth);
    r.cnt_down  = dssm_pkg::CNT_W'(down_depth);
    r.cnt_total = dssm_pkg::CNT_W'(up_depth + down_depth);
    return r;
  endfunction

  always @(posedge clk) begin
    stack_result_t want;
    stack_result_t got;
    if (!rst_n) begin
      up_depth   = 0;
      down_depth = 0;
      expected_q.delete();
      err_cnt    = 0;
      got_cnt    = 0;
      full_cnt   = 0;
      empty_cnt  = 0;
    end else begin
      if (in_tvalid && in_tready)
        expected_q.push_back(apply_stack_action(dssm_pkg::action_t'(in_tuser[1:0]),
                                                in_tuser[2],
                                                in_tdata[dssm_pkg::KEY_W-1:0]));
      if (out_tvalid && out_tready) begin
        got_cnt++;
        got.status    = dssm_pkg::status_t'(out_tuser[1:0]);
        got.key       = out_tdata[dssm_pkg::KEY_W-1:0];
        got.pos       = out_tdata[POS_LO +: dssm_pkg::POS_W];
        got.cnt_up    = out_tdata[C1_LO +: dssm_pkg::CNT_W];
        got.cnt_down  = out_tdata[C2_LO +: dssm_pkg::CNT_W];
        got.cnt_total = out_tdata[CT_LO +: dssm_pkg::CNT_W];
        if (got.status == dssm_pkg::ST_FULL) full_cnt++;
        if (got.status == dssm_pkg::ST_EMPTY) empty_cnt++;
        if (expected_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: result beat %0d arrived with nothing expected", $time, got_cnt);
        end else begin
          want = expected_q.pop_front();
          if (got.status !== want.status || got.key !== want.key || got.pos !== want.pos ||
              got.cnt_up !== want.cnt_up || got.cnt_down !== want.cnt_down ||
              got.cnt_total !== want.cnt_total) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("%0t: result beat %0d mismatch (expected / actual)", $time, got_cnt);
              $display("  status %0d/%0d key %h/%h pos %0d/%0d counts %0d,%0d,%0d / %0d,%0d,%0d",
                       want.status, got.status, want.key, got.key, want.pos, got.pos,
                       want.cnt_up, want.cnt_down, want.cnt_total,
                       got.cnt_up, got.cnt_down, got.cnt_total);
            end
          end
        end
      end
    end
    mismatches    <= err_cnt;
    pending_beats <= expected_q.size();
    results_seen  <= got_cnt;
    full_seen     <= full_cnt;
    empty_seen    <= empty_cnt;
  end

endmodule

// ===== test/tb_dual_stack_shared_memory.sv =====
`timescale 1ns / 100ps

module tb_dual_stack_shared_memory;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASE_BEATS   = 150;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [dssm_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;  // key_in
  logic [dssm_pkg::IN_TUSER_W-1:0]  in_tuser   = '0;  // action[1:0], stack_select
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  // key_out, position, count_first, count_second, count_total, zero pad
  logic [dssm_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [dssm_pkg::OUT_TUSER_W-1:0] out_tuser;        // status

  int mismatches;
  int pending_beats;
  int results_seen;
  int full_seen;
  int empty_seen;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int beats_sent  = 0;
  int cycle_count = 0;

  dual_stack_shared_memory u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  stack_result_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .mismatches    (mismatches),
    .pending_beats (pending_beats),
    .results_seen  (results_seen),
    .full_seen     (full_seen),
    .empty_seen    (empty_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results owed", cycle_count, pending_beats);
      $display("simulation failed");
      $finish;
    end
  end

  // present one beat, optionally after random idle cycles, and hold until taken
  task automatic send_beat(dssm_pkg::action_t act, logic sel,
                           logic [dssm_pkg::KEY_W-1:0] key);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {sel, act};
    in_tdata  <= key;
    do @(posedge clk); while (!in_tready);
    beats_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    // the owed count is registered behind the checker's queue
    @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic logic [dssm_pkg::KEY_W-1:0] pick_key();
    logic [dssm_pkg::KEY_W-1:0] k;
    case ($urandom_range(0, 11))
      0:       k = 32'h8000_0000;
      1:       k = 32'h7fff_ffff;
      2:       k = 32'h0000_0000;
      3:       k = 32'hffff_ffff;
      default: k = $urandom;
    endcase
    return k;
  endfunction

  // bursts of fill, drain, mixed traffic and clears so both full and empty get hit often
  task automatic stack_traffic(int beats);
    int                left;
    int                kind;
    int                len;
    int                roll;
    dssm_pkg::action_t act;
    left = beats;
    while (left > 0) begin
      kind = $urandom_range(0, 9);
      len  = (kind <= 3) ? $urandom_range(20, 80) : $urandom_range(4, 40);
      if (kind == 9) len = 1;
      if (len > left) len = left;
      for (int i = 0; i < len; i++) begin
        roll = $urandom_range(0, 99);
        if (kind <= 3) act = (roll < 95) ? dssm_pkg::ACT_PUSH : dssm_pkg::ACT_PEEK;
        else if (kind <= 6) act = (roll < 80) ? dssm_pkg::ACT_POP : dssm_pkg::ACT_PEEK;
        else if (kind <= 8) act = (roll < 3) ? dssm_pkg::ACT_CLEAR
                                             : dssm_pkg::action_t'(roll % 3);
        else act = dssm_pkg::ACT_CLEAR;
        send_beat(act, 1'($urandom_range(0, 1)), pick_key());
      end
      left -= len;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme keys on both stacks, every action, empty and clear cases
    send_beat(dssm_pkg::ACT_PUSH,  1'b0, 32'h7fff_ffff);
    send_beat(dssm_pkg::ACT_PUSH,  1'b0, 32'h8000_0000);
    send_beat(dssm_pkg::ACT_PUSH,  1'b1, 32'h0000_0000);
    send_beat(dssm_pkg::ACT_PUSH,  1'b1, 32'hffff_ffff);
    send_beat(dssm_pkg::ACT_PEEK,  1'b0, 32'h0000_0000);
    send_beat(dssm_pkg::ACT_PEEK,  1'b1, 32'hffff_ffff);
    send_beat(dssm_pkg::ACT_POP,   1'b0, 32'h0000_0000);
    send_beat(dssm_pkg::ACT_POP,   1'b0, 32'hffff_ffff);
    send_beat(dssm_pkg::ACT_POP,   1'b0, 32'h0000_0000);
    send_beat(dssm_pkg::ACT_POP,   1'b1, 32'h0000_0000);
    send_beat(dssm_pkg::ACT_PEEK,  1'b1, 32'h0000_0000);
    send_beat(dssm_pkg::ACT_POP,   1'b1, 32'h0000_0000);
    send_beat(dssm_pkg::ACT_POP,   1'b1, 32'h0000_0000);
    send_beat(dssm_pkg::ACT_PEEK,  1'b0, 32'h0000_0000);
    send_beat(dssm_pkg::ACT_PUSH,  1'b0, 32'h5555_5555);
    send_beat(dssm_pkg::ACT_PUSH,  1'b1, 32'haaaa_aaaa);
    send_beat(dssm_pkg::ACT_CLEAR, 1'b1, 32'h1234_5678);
    send_beat(dssm_pkg::ACT_PEEK,  1'b0, 32'h0000_0000);
    send_beat(dssm_pkg::ACT_PEEK,  1'b1, 32'h0000_0000);
    send_beat(dssm_pkg::ACT_PUSH,  1'b1, 32'h0000_0001);
    send_beat(dssm_pkg::ACT_CLEAR, 1'b0, 32'h0000_0000);
    send_beat(dssm_pkg::ACT_POP,   1'b1, 32'h0000_0000);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 61; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      stack_traffic(PHASE_BEATS);
      // sender holds off until every result of the phase is back
      wait_drained();
    end

    $display("sent %0d beats over four pacing phases, checked %0d results", beats_sent,
             results_seen);
    $display("full status seen %0d times, empty status %0d times, %0d mismatches",
             full_seen, empty_seen, mismatches);
    if (mismatches == 0 && pending_beats == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
